// File: hdl/rlqm_pkg.sv
// Shared types and codes for the record lock queue manager.
// No dependencies; imported by the core only.
`default_nettype none

package rlqm_pkg;

    localparam int TABLE_BITS  = 10;
    localparam int RECORD_BITS = 16;
    localparam int KEY_BITS    = TABLE_BITS + RECORD_BITS;
    localparam int REQ_ID_BITS = 8;
    localparam int STATUS_BITS = 3;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_GRANTED    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_QUEUED     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_HANDED_ON  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_IDLE       = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NO_HOLDER  = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_QUEUE_FULL = 3'd6;

    typedef struct packed {
        logic                   req_type;
        logic [TABLE_BITS-1:0]  table_number;
        logic [RECORD_BITS-1:0] record_key;
        logic [REQ_ID_BITS-1:0] requester_id;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   grant_valid;
        logic [REQ_ID_BITS-1:0] granted_requester;
    } out_item_t;

endpackage

`default_nettype wire

// File: hdl/record_lock_queue_manager_core.sv
// Exclusive record lock manager: one FIFO of requesters per active record key.
// Depends on rlqm_pkg (types, status codes) and rlqm_ram (waiter storage).
//
// Usage:
//   Requests enter on in_valid/in_ready with an in_item_t payload. An acquire
//   on a free key takes the lowest free key slot and is granted at once; an
//   acquire on an active key queues the requester behind the holder. A release
//   drops the holder and hands the lock to the next waiter, or frees the slot.
//   Every item produces exactly one result on out_valid/out_ready.
//
//   An item is held in an input register, where the key compare over all
//   slots and the slot update happen, and its result is registered in the
//   result register. One item is taken every cycle while the receiver does
//   not stall; the limit is the single read-modify-write of slot state per
//   cycle. A hand-on reads the next waiter from the waiter RAM, whose
//   registered read port lands alongside the result register.
//
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops until the result is taken.
//   Reset clears all slots, ring heads and counts; no clearing pass is needed.
`default_nettype none

module record_lock_queue_manager_core
    import rlqm_pkg::*;
#(
    parameter int KEY_SLOTS      = 16,
    parameter int QUEUE_DEPTH    = 8,
    parameter int REQUESTER_BITS = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = QW + 1;
    localparam int RW = (REQUESTER_BITS < REQ_ID_BITS) ? REQUESTER_BITS : REQ_ID_BITS;
    localparam int RAM_DEPTH = KEY_SLOTS * (1 << QW);
    localparam int AW = $clog2(RAM_DEPTH);

    // Handshake and pipeline control
    logic      in_valid_reg, in_valid_next;
    in_item_t  item_reg;
    logic      out_valid_reg, out_valid_next;
    logic      fire;

    // Slot state
    logic [KEY_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [KEY_BITS-1:0]  slot_key_reg  [KEY_SLOTS];
    logic [QW-1:0]        ring_head_reg [KEY_SLOTS];
    logic [QW-1:0]        ring_head_next[KEY_SLOTS];
    logic [CW-1:0]        ring_count_reg [KEY_SLOTS];
    logic [CW-1:0]        ring_count_next[KEY_SLOTS];

    // Result register
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   grant_reg, grant_next;
    logic [RW-1:0]          gid_reg, gid_next;
    logic                   from_ram_reg, from_ram_next;

    // Stage logic
    logic [KEY_BITS-1:0]  key;
    logic [RW-1:0]        req_id;
    logic [KEY_SLOTS-1:0] match_vec;
    logic                 hit;
    logic [SW-1:0]        hit_idx;
    logic                 has_free;
    logic [SW-1:0]        free_idx;
    logic [QW-1:0]        cur_head;
    logic [CW-1:0]        cur_count;
    logic [QW-1:0]        head_inc;
    logic [PW-1:0]        pos_sum;
    logic [QW-1:0]        tail_pos;
    logic                 key_write;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_rdata;

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Key lookup and lowest free slot
    assign key    = {item_reg.table_number, item_reg.record_key};
    assign req_id = item_reg.requester_id[RW-1:0];

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int s = KEY_SLOTS - 1; s >= 0; s--)
        begin
            match_vec[s] = slot_valid_reg[s] && (slot_key_reg[s] == key);
            if (match_vec[s])
            begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
            if (!slot_valid_reg[s])
            begin
                has_free = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    assign cur_head  = ring_head_reg[hit_idx];
    assign cur_count = ring_count_reg[hit_idx];
    assign head_inc  = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + QW'(1);
    assign pos_sum   = PW'(cur_head) + PW'(cur_count);
    assign tail_pos  = (pos_sum >= PW'(QUEUE_DEPTH)) ? QW'(pos_sum - PW'(QUEUE_DEPTH))
                                                     : pos_sum[QW-1:0];

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        for (int s = 0; s < KEY_SLOTS; s++)
        begin
            ring_head_next[s]  = ring_head_reg[s];
            ring_count_next[s] = ring_count_reg[s];
        end
        status_next   = status_reg;
        grant_next    = grant_reg;
        gid_next      = gid_reg;
        from_ram_next = from_ram_reg;
        key_write     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = {hit_idx, tail_pos};
        ram_re        = 1'b0;
        ram_raddr     = {hit_idx, head_inc};

        if (fire)
        begin
            grant_next    = 1'b0;
            gid_next      = '0;
            from_ram_next = 1'b0;
            if (item_reg.req_type == REQ_RELEASE)
            begin
                if (!hit || cur_count == '0)
                begin
                    status_next = ST_NO_HOLDER;
                end
                else
                begin
                    ring_head_next[hit_idx]  = head_inc;
                    ring_count_next[hit_idx] = cur_count - CW'(1);
                    if (cur_count == CW'(1))
                    begin
                        slot_valid_next[hit_idx] = 1'b0;
                        status_next = ST_IDLE;
                    end
                    else
                    begin
                        // The next holder's id arrives from the RAM read register.
                        status_next   = ST_HANDED_ON;
                        grant_next    = 1'b1;
                        from_ram_next = 1'b1;
                        ram_re        = 1'b1;
                    end
                end
            end
            else if (hit)
            begin
                if (cur_count >= CW'(QUEUE_DEPTH))
                begin
                    status_next = ST_QUEUE_FULL;
                end
                else
                begin
                    ram_we = 1'b1;
                    ring_count_next[hit_idx] = cur_count + CW'(1);
                    status_next = ST_QUEUED;
                end
            end
            else if (!has_free)
            begin
                status_next = ST_TABLE_FULL;
            end
            else
            begin
                slot_valid_next[free_idx] = 1'b1;
                ring_head_next[free_idx]  = '0;
                ring_count_next[free_idx] = CW'(1);
                key_write   = 1'b1;
                ram_we      = 1'b1;
                ram_waddr   = {free_idx, {QW{1'b0}}};
                status_next = ST_GRANTED;
                grant_next  = 1'b1;
                gid_next    = req_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            for (int s = 0; s < KEY_SLOTS; s++)
            begin
                ring_head_reg[s]  <= '0;
                ring_count_reg[s] <= '0;
            end
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            slot_valid_reg <= slot_valid_next;
            for (int s = 0; s < KEY_SLOTS; s++)
            begin
                ring_head_reg[s]  <= ring_head_next[s];
                ring_count_reg[s] <= ring_count_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        if (key_write)
        begin
            slot_key_reg[free_idx] <= key;
        end
        status_reg   <= status_next;
        grant_reg    <= grant_next;
        gid_reg      <= gid_next;
        from_ram_reg <= from_ram_next;
    end

    rlqm_ram #(
        .WIDTH (RW),
        .DEPTH (RAM_DEPTH)
    ) u_waiter_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_id),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid                  = out_valid_reg;
    assign out_item.status            = status_reg;
    assign out_item.grant_valid       = grant_reg;
    assign out_item.granted_requester = REQ_ID_BITS'(from_ram_reg ? ram_rdata : gid_reg);

    // An active key lives in at most one slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(match_vec))
        else $error("record key found in more than one slot");

    // A grant is flagged exactly for the two granting status codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (grant_reg == (status_reg == ST_GRANTED ||
                                         status_reg == ST_HANDED_ON)))
        else $error("grant flag disagrees with status");

    // A hand-on always takes the next holder from the waiter RAM.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (out_valid_reg && from_ram_reg && status_reg == ST_HANDED_ON))
        else $error("hand-on result not sourced from waiter RAM");

    // The selected slot's ring is never empty while active nor over depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && hit) |-> (cur_count != '0 && cur_count <= CW'(QUEUE_DEPTH)))
        else $error("active slot ring count out of range");

endmodule

`default_nettype wire

// File: hdl/rlqm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies. The read register holds its value when no read is issued.
`default_nettype none

module rlqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
